[hdl/sbusfr_pkg.sv]
// Shared types and constants for the SBUS frame receiver.
package sbusfr_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'h0F;
	localparam logic [7:0] FOOTER_BYTE = 8'h00;
	localparam logic [4:0] FRAME_LAST = 5'd24;
	localparam logic [4:0] PAYLOAD_FIRST = 5'd1;
	localparam logic [4:0] PAYLOAD_LAST = 5'd22;
	localparam int PAYLOAD_BYTES = 22;
	localparam int PAYLOAD_BITS = PAYLOAD_BYTES * 8;
	localparam int CHANNEL_BITS = 11;
	localparam logic [3:0] LAST_CHANNEL = 4'd15;

	typedef logic [PAYLOAD_BITS-1:0] payload_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_error;
	} rx_word_t;

	typedef struct packed {
		logic [3:0]  channel_index;
		logic [10:0] channel_value;
		logic        last_channel;
	} ch_word_t;

	// Handshake between the frame queue and the channel emitter
	typedef struct packed {
		logic valid;
	} q_ctl_t;

endpackage

[hdl/sbusfr_front.sv]
// Byte tracker: checks header and footer, gathers payload, pushes whole frames.
module sbusfr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  sbusfr_pkg::rx_word_t rx_word,
	input  logic                 q_full,
	output logic                 push,
	output sbusfr_pkg::payload_t frame
);
	import sbusfr_pkg::*;

	logic [4:0] pos_q;
	payload_t   store_q;
	logic       accept;
	logic       bad;

	// Only a full frame queue holds the serial side back
	assign rx_stall = q_full;
	assign accept = rx_valid && !rx_stall;
	assign bad = rx_word.rx_error ||
		(pos_q == 5'd0 && rx_word.rx_byte != HEADER_BYTE) ||
		(pos_q == FRAME_LAST && rx_word.rx_byte != FOOTER_BYTE) ||
		(pos_q > FRAME_LAST);
	assign push = accept && !bad && pos_q == FRAME_LAST;
	assign frame = store_q;

	// Byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
		end else if (accept) begin
			if (bad || pos_q == FRAME_LAST) begin
				pos_q <= 5'd0;
			end else begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	// Payload bytes shift in from the top; byte 1 ends at the bottom
	always_ff @(posedge clk) begin
		if (accept && !bad && pos_q >= PAYLOAD_FIRST && pos_q <= PAYLOAD_LAST) begin
			store_q <= {rx_word.rx_byte, store_q[PAYLOAD_BITS-1:8]};
		end
	end

endmodule

[hdl/sbusfr_queue.sv]
// Two-entry queue of complete payload frames.
module sbusfr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sbusfr_pkg::payload_t push_frame,
	output logic                 full,
	output sbusfr_pkg::q_ctl_t   ctl_out,
	input  logic                 pop,
	output sbusfr_pkg::payload_t pop_frame
);
	import sbusfr_pkg::*;

	payload_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign ctl_out.valid = count_q != 2'd0;
	assign pop_frame = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Frame storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("frame queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full frame queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("pop from empty frame queue");
`endif

endmodule

[hdl/sbusfr_back.sv]
// Channel emitter: unpacks sixteen 11-bit channels from a frame, one per cycle while ch_stall is low.
module sbusfr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbusfr_pkg::q_ctl_t   q_ctl,
	input  sbusfr_pkg::payload_t q_frame,
	output logic                 q_pop,
	output logic                 ch_valid,
	input  logic                 ch_stall,
	output sbusfr_pkg::ch_word_t ch_word
);
	import sbusfr_pkg::*;

	payload_t  shift_q;
	logic [3:0] ch_q;
	logic       busy_q;
	logic       out_valid_q;
	ch_word_t   out_q;
	logic       out_free;
	logic       adv;
	logic       ending;

	assign out_free = !out_valid_q || !ch_stall;
	assign adv = busy_q && out_free;
	assign ending = adv && ch_q == LAST_CHANNEL;
	assign q_pop = q_ctl.valid && (!busy_q || ending);
	assign ch_valid = out_valid_q;
	assign ch_word = out_q;

	// Emit sequencing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				ch_q <= ch_q + 4'd1;
				if (ch_q == LAST_CHANNEL) begin
					busy_q <= 1'b0;
				end
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				ch_q <= 4'd0;
			end
		end
	end

	// Payload shifter and word data
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.channel_index <= ch_q;
			out_q.channel_value <= shift_q[CHANNEL_BITS-1:0];
			out_q.last_channel <= ch_q == LAST_CHANNEL;
			shift_q <= {{CHANNEL_BITS{1'b0}}, shift_q[PAYLOAD_BITS-1:CHANNEL_BITS]};
		end
		if (q_pop) begin
			shift_q <= q_frame;
		end
	end

`ifndef ASSERT_OFF
	a_last_is_fifteen: assert property (@(posedge clk) disable iff (!arst_n)
		ch_valid && ch_word.last_channel |-> ch_word.channel_index == LAST_CHANNEL)
		else $error("last channel flag on wrong index");
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> ch_q == 4'd0) else $error("channel count not cleared when idle");
	a_index_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		ch_valid && !ch_stall && !ch_word.last_channel |=>
		!ch_valid || ch_word.channel_index == $past(ch_word.channel_index) + 4'd1)
		else $error("channel words out of order");
`endif

endmodule

[hdl/sbus_frame_receiver.sv]
// Top level: once the footer byte is taken, the frame is written to the queue, then loaded into the emitter's shifter.
// Sixteen channel words then follow from the output register at one a cycle while the output is not stalled.
// Bytes are taken at one a cycle while rx_stall is low; rx_stall rises only while two frames wait to be emitted.
// The frame queue holds two frames; the emitter shifts a frame out 11 bits per cycle while the output is not stalled.
// arst_n clears the byte position, queue and emitter at once; no clearing pass follows.
module sbus_frame_receiver (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  sbusfr_pkg::rx_word_t rx_word,
	output logic                 ch_valid,
	input  logic                 ch_stall,
	output sbusfr_pkg::ch_word_t ch_word
);
	import sbusfr_pkg::*;

	logic     q_full;
	logic     push;
	logic     pop;
	payload_t push_frame;
	payload_t pop_frame;
	q_ctl_t   q_ctl;

	sbusfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_word  (rx_word),
		.q_full   (q_full),
		.push     (push),
		.frame    (push_frame)
	);

	sbusfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.full       (q_full),
		.ctl_out    (q_ctl),
		.pop        (pop),
		.pop_frame  (pop_frame)
	);

	sbusfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_ctl    (q_ctl),
		.q_frame  (pop_frame),
		.q_pop    (pop),
		.ch_valid (ch_valid),
		.ch_stall (ch_stall),
		.ch_word  (ch_word)
	);

endmodule

[tb/sbus_frame_checker.sv]
// Checker for the SBUS frame receiver: predicts channel words from accepted bytes and compares.
module sbus_frame_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	input  logic                 rx_stall,
	input  sbusfr_pkg::rx_word_t rx_word,
	input  logic                 ch_valid,
	input  logic                 ch_stall,
	input  sbusfr_pkg::ch_word_t ch_word,
	output int                   words_pending,
	output int                   error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import sbusfr_pkg::*;

	// Frame tracker state
	logic [4:0] frame_pos;
	logic [7:0] frame_payload [PAYLOAD_BYTES];
	ch_word_t   expected_channels [$];

	initial begin
		error_count = 0;
		words_pending = 0;
		frame_pos = '0;
		foreach (frame_payload[i]) frame_payload[i] = '0;
	end

	// Advance the frame position by one byte; a good footer queues sixteen channel words
	task automatic take_frame_byte(input rx_word_t w);
		payload_t bits;
		ch_word_t cw;
		if (frame_pos > FRAME_LAST) begin
			frame_pos = '0;
		end else if (w.rx_error || (frame_pos == 0 && w.rx_byte != HEADER_BYTE) ||
				(frame_pos == FRAME_LAST && w.rx_byte != FOOTER_BYTE)) begin
			frame_pos = '0;
		end else if (frame_pos < FRAME_LAST) begin
			// flags byte moves the position on but is not kept
			if (frame_pos >= PAYLOAD_FIRST && frame_pos <= PAYLOAD_LAST) begin
				frame_payload[frame_pos - 1] = w.rx_byte;
			end
			frame_pos = frame_pos + 5'd1;
		end else begin
			frame_pos = '0;
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				bits[i*8 +: 8] = frame_payload[i];
			end
			// channels are packed LSB first across the payload
			for (int ch = 0; ch < 16; ch++) begin
				cw.channel_index = 4'(ch);
				cw.channel_value = bits[ch*CHANNEL_BITS +: CHANNEL_BITS];
				cw.last_channel = (4'(ch) == LAST_CHANNEL);
				expected_channels.push_back(cw);
			end
		end
	endtask

	// Compare each accepted channel word with the oldest prediction
	task automatic check_channel_word(input ch_word_t got);
		ch_word_t want;
		if (expected_channels.size() == 0) begin
			$error("unexpected channel word: index %0d value %0d last %0b",
				got.channel_index, got.channel_value, got.last_channel);
			error_count++;
		end else begin
			want = expected_channels.pop_front();
			if (got.channel_index !== want.channel_index) begin
				$error("channel_index: expected %0d, got %0d",
					want.channel_index, got.channel_index);
				error_count++;
			end
			if (got.channel_value !== want.channel_value) begin
				$error("channel_value: expected %0d, got %0d",
					want.channel_value, got.channel_value);
				error_count++;
			end
			if (got.last_channel !== want.last_channel) begin
				$error("last_channel: expected %0b, got %0b",
					want.last_channel, got.last_channel);
				error_count++;
			end
		end
	endtask

	// Watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos = '0;
			expected_channels.delete();
			words_pending <= 0;
		end else begin
			if (ch_valid && !ch_stall) check_channel_word(ch_word);
			if (rx_valid && !rx_stall) take_frame_byte(rx_word);
			words_pending <= expected_channels.size();
		end
	end

endmodule

[tb/tb_sbus_frame_receiver.sv]
// Testbench top for the SBUS frame receiver: byte stimulus, output stalls and verdict.
module tb_sbus_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	import sbusfr_pkg::*;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
	typedef enum int {FAULT_NONE, FAULT_RX_ERROR, FAULT_FOOTER} fault_t;
	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

	localparam int FRAME_BYTES = 25;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 200;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     rx_valid = 1'b0;
	logic     rx_stall;
	rx_word_t rx_word = '0;
	logic     ch_valid;
	logic     ch_stall = 1'b0;
	ch_word_t ch_word;

	int words_pending;
	int error_count;

	int items_sent = 0;
	int burst_left = 0;
	bit no_gaps = 1'b0;
	int hold_requests = 0;
	bit pressure_done = 1'b0;

	sbus_frame_receiver DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_word  (rx_word),
		.ch_valid (ch_valid),
		.ch_stall (ch_stall),
		.ch_word  (ch_word)
	);

	sbus_frame_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_word       (rx_word),
		.ch_valid      (ch_valid),
		.ch_stall      (ch_stall),
		.ch_word       (ch_word),
		.words_pending (words_pending),
		.error_count   (error_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one byte, with bursts and gaps, and wait until it is taken
	task automatic send_byte(input logic [7:0] b, input logic err);
		if (burst_left == 0 && !no_gaps) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		rx_valid <= 1'b1;
		rx_word <= '{rx_byte: b, rx_error: err};
		do @(posedge clk); while (rx_stall);
		if (burst_left > 0) burst_left--;
		items_sent++;
	endtask

	// One frame: header, 22 payload bytes, flags, footer; optionally broken
	task automatic send_frame(input fill_t fill, input fault_t fault);
		logic [7:0] b;
		int err_at;
		err_at = $urandom_range(0, FRAME_BYTES - 1);
		for (int p = 0; p < FRAME_BYTES; p++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom_range(0, 255));
			endcase
			if (p == 0) b = HEADER_BYTE;
			if (p == FRAME_BYTES - 1) begin
				b = (fault == FAULT_FOOTER) ? 8'($urandom_range(1, 255)) : FOOTER_BYTE;
			end
			if (fault == FAULT_RX_ERROR && p == err_at) begin
				send_byte(b, 1'b1);
				break;
			end
			send_byte(b, 1'b0);
		end
	endtask

	// Stop offering and let every predicted word come out
	task automatic drain_channels();
		rx_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
	endtask

	// Receiver stall pattern, with a long hold when asked for
	initial begin
		int hold_served;
		int hold_left;
		int mode_left;
		stall_mode_t stall_mode;
		hold_served = 0;
		hold_left = 0;
		mode_left = 0;
		stall_mode = STALL_NONE;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ch_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (stall_mode)
					STALL_NONE:   ch_stall <= 1'b0;
					STALL_RANDOM: ch_stall <= ($urandom_range(0, 1) == 1);
					default:      ch_stall <= (mode_left % 4 == 0);
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: wrong header, error on a header, stray byte, all-ones frame
		send_byte(8'h00, 1'b0);
		send_byte(HEADER_BYTE, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_frame(FILL_ONES, FAULT_NONE);
		drain_channels();

		// random: mostly good frames, some broken ones and line noise
		while (items_sent < ITEM_TARGET) begin
			if (!pressure_done && items_sent >= 120) begin
				// output held off while frames keep coming, then a full drain
				pressure_done = 1'b1;
				no_gaps = 1'b1;
				hold_requests++;
				repeat (4) send_frame(FILL_RANDOM, FAULT_NONE);
				no_gaps = 1'b0;
				drain_channels();
			end
			r = $urandom_range(0, 99);
			if (r < 5) send_frame(FILL_ZERO, FAULT_NONE);
			else if (r < 10) send_frame(FILL_ONES, FAULT_NONE);
			else if (r < 70) send_frame(FILL_RANDOM, FAULT_NONE);
			else if (r < 80) send_frame(FILL_RANDOM, FAULT_RX_ERROR);
			else if (r < 88) send_frame(FILL_RANDOM, FAULT_FOOTER);
			else begin
				repeat ($urandom_range(1, 4)) begin
					send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
				end
			end
		end

		drain_channels();
		repeat (20) @(posedge clk);
		if (error_count == 0 && words_pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Run limit
	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[sbus_frame_receiver.f]
hdl/sbusfr_pkg.sv
hdl/sbusfr_front.sv
hdl/sbusfr_queue.sv
hdl/sbusfr_back.sv
hdl/sbus_frame_receiver.sv
tb/sbus_frame_checker.sv
tb/tb_sbus_frame_receiver.sv
